/* rtl/core/rpn_pkg.sv */
// Shared types and constants of the RPN stack calculator.
package rpn_pkg;

    localparam int DATA_W = 32;

    localparam logic [2:0] ST_PRINTED   = 3'd0;
    localparam logic [2:0] ST_UNDERFLOW = 3'd1;
    localparam logic [2:0] ST_OVERFLOW  = 3'd2;
    localparam logic [2:0] ST_DIVZERO   = 3'd3;
    localparam logic [2:0] ST_END       = 3'd4;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_PRINT  = 8'h21;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_MOD    = 8'h25;
    localparam logic [7:0] CH_MUL    = 8'h2A;
    localparam logic [7:0] CH_ADD    = 8'h2B;
    localparam logic [7:0] CH_SUB    = 8'h2D;
    localparam logic [7:0] CH_DIV    = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_TILDE  = 8'h7E;

    // controller to datapath
    typedef struct packed {
        logic       load_char;
        logic       acc_digit;
        logic       set_comment;
        logic       clr_comment;
        logic       clear_all;
        logic       push;
        logic       drop_num;
        logic       rd_top;
        logic       rd_second;
        logic       load_b;
        logic       load_a;
        logic       div_start;
        logic       ld_alu;
        logic       ld_div;
        logic       wr_res;
        logic       load_val;
        logic       pop;
        logic       emit;
        logic [2:0] emit_status;
        logic       emit_last;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_digit;
        logic is_op;
        logic is_div;
        logic is_print;
        logic is_tilde;
        logic is_dollar;
        logic is_nl;
        logic in_comment;
        logic pending;
        logic full;
        logic lt2;
        logic empty;
        logic b_zero;
        logic div_done;
        logic out_free;
    } t_dp_stat;

endpackage

/* rtl/core/rpn_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/rpn_div.sv */
// Iterative signed 32-bit divider, one quotient bit per cycle, C truncation.
module rpn_div
    import rpn_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_dividend,
    input  logic [DATA_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DATA_W-1:0] o_quot,
    output logic [DATA_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(DATA_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_dvs;
    logic              r_neg_q;
    logic              r_neg_r;

    logic [DATA_W:0]   w_num;
    logic [DATA_W+1:0] w_diff;
    logic              w_ge;
    logic [DATA_W-1:0] w_abs_n;
    logic [DATA_W-1:0] w_abs_d;

    assign w_abs_n = i_dividend[DATA_W-1] ? (~i_dividend + DATA_W'(1)) : i_dividend;
    assign w_abs_d = i_divisor[DATA_W-1]  ? (~i_divisor + DATA_W'(1))  : i_divisor;

    assign w_num  = {r_rem, r_quo[DATA_W-1]};
    assign w_diff = {1'b0, w_num} - {2'b00, r_dvs};
    assign w_ge   = ~w_diff[DATA_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DATA_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= '0;
            r_quo   <= w_abs_n;
            r_dvs   <= w_abs_d;
            r_neg_q <= i_dividend[DATA_W-1] ^ i_divisor[DATA_W-1];
            r_neg_r <= i_dividend[DATA_W-1];
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DATA_W-1:0] : w_num[DATA_W-1:0];
            r_quo <= {r_quo[DATA_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg_q ? (~r_quo + DATA_W'(1)) : r_quo;
    assign o_rem  = r_neg_r ? (~r_rem + DATA_W'(1)) : r_rem;

endmodule

/* rtl/core/rpn_dp.sv */
// Datapath: character decode, number builder, operand stack, ALU, divider, result register.
module rpn_dp
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [7:0]         i_char_in,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic signed [31:0] o_value,
    output logic [2:0]         o_status,
    output logic               o_last
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [7:0]        r_char;
    logic [CW-1:0]     r_count;
    logic [DATA_W-1:0] r_acc;
    logic              r_pend;
    logic              r_comment;
    logic [DATA_W-1:0] r_a;
    logic [DATA_W-1:0] r_b;
    logic [DATA_W-1:0] r_res;
    logic [DATA_W-1:0] r_val;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_value;
    logic [2:0]        r_out_status;
    logic              r_out_last;

    logic [7:0]        w_dig8;
    logic [DATA_W-1:0] w_acc_next;
    logic [DATA_W-1:0] w_prod;
    logic [DATA_W-1:0] w_alu;
    logic [DATA_W-1:0] w_rdata;
    logic [DATA_W-1:0] w_quot;
    logic [DATA_W-1:0] w_rem;
    logic              w_div_done;
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [DATA_W-1:0] w_wdata;
    logic [AW-1:0]     w_raddr;
    logic [CW-1:0]     w_cnt_m1;
    logic [CW-1:0]     w_cnt_m2;

    assign w_dig8     = r_char - CH_ZERO;
    assign w_acc_next = (r_acc << 3) + (r_acc << 1) + {{(DATA_W-4){1'b0}}, w_dig8[3:0]};
    assign w_prod     = r_a * r_b;
    assign w_cnt_m1   = r_count - CW'(1);
    assign w_cnt_m2   = r_count - CW'(2);

    always_comb begin
        unique case (r_char)
            CH_ADD:  w_alu = r_a + r_b;
            CH_SUB:  w_alu = r_a - r_b;
            default: w_alu = w_prod;
        endcase
    end

    assign w_we    = i_cmd.push | i_cmd.wr_res;
    assign w_waddr = i_cmd.push ? r_count[AW-1:0] : w_cnt_m2[AW-1:0];
    assign w_wdata = i_cmd.push ? r_acc : r_res;
    assign w_raddr = i_cmd.rd_second ? w_cnt_m2[AW-1:0] : w_cnt_m1[AW-1:0];

    rpn_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    rpn_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_a),
        .i_divisor  (r_b),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_acc       <= '0;
            r_pend      <= 1'b0;
            r_comment   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear_all) begin
                r_count   <= '0;
                r_acc     <= '0;
                r_pend    <= 1'b0;
                r_comment <= 1'b0;
            end else begin
                if (i_cmd.set_comment) begin
                    r_comment <= 1'b1;
                end else if (i_cmd.clr_comment) begin
                    r_comment <= 1'b0;
                end
                if (i_cmd.acc_digit) begin
                    r_acc  <= w_acc_next;
                    r_pend <= 1'b1;
                end else if (i_cmd.push || i_cmd.drop_num) begin
                    r_acc  <= '0;
                    r_pend <= 1'b0;
                end
                if (i_cmd.push) begin
                    r_count <= r_count + CW'(1);
                end else if (i_cmd.wr_res || i_cmd.pop) begin
                    r_count <= w_cnt_m1;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_char) begin
            r_char <= i_char_in;
        end
        if (i_cmd.load_b) begin
            r_b <= w_rdata;
        end
        if (i_cmd.load_a) begin
            r_a <= w_rdata;
        end
        if (i_cmd.ld_alu) begin
            r_res <= w_alu;
        end else if (i_cmd.ld_div) begin
            r_res <= (r_char == CH_DIV) ? w_quot : w_rem;
        end
        if (i_cmd.load_val) begin
            r_val <= w_rdata;
        end
        if (i_cmd.emit) begin
            r_out_status <= i_cmd.emit_status;
            r_out_last   <= i_cmd.emit_last;
            r_out_value  <= (i_cmd.emit_status == ST_PRINTED) ? r_val : '0;
        end
    end

    assign o_stat.is_digit   = (r_char >= CH_ZERO) && (r_char <= CH_NINE);
    assign o_stat.is_op      = (r_char == CH_ADD) || (r_char == CH_SUB) || (r_char == CH_MUL)
                             || (r_char == CH_DIV) || (r_char == CH_MOD);
    assign o_stat.is_div     = (r_char == CH_DIV) || (r_char == CH_MOD);
    assign o_stat.is_print   = (r_char == CH_PRINT);
    assign o_stat.is_tilde   = (r_char == CH_TILDE);
    assign o_stat.is_dollar  = (r_char == CH_DOLLAR);
    assign o_stat.is_nl      = (r_char == CH_NL);
    assign o_stat.in_comment = r_comment;
    assign o_stat.pending    = r_pend;
    assign o_stat.full       = (r_count == CW'(STACK_DEPTH));
    assign o_stat.lt2        = (r_count < CW'(2));
    assign o_stat.empty      = (r_count == '0);
    assign o_stat.b_zero     = (r_b == '0);
    assign o_stat.div_done   = w_div_done;
    assign o_stat.out_free   = ~r_out_valid | i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_value     = signed'(r_out_value);
    assign o_status    = r_out_status;
    assign o_last      = r_out_last;

endmodule

/* rtl/core/rpn_ctrl.sv */
// Controller: sequences one character through decode, stack access, execute and result emission.
module rpn_ctrl
    import rpn_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_OPER,
        S_RD1,
        S_RD2,
        S_EXEC,
        S_DIVW,
        S_WB,
        S_PRNT,
        S_FIN
    } t_state;

    t_state     r_state, n_state;
    logic       r_ovf, n_ovf;
    logic       r_has_res, n_has_res;
    logic [2:0] r_code, n_code;

    always_comb begin
        n_state   = r_state;
        n_ovf     = r_ovf;
        n_has_res = r_has_res;
        n_code    = r_code;
        o_cmd     = '0;

        unique case (r_state)
            S_IDLE: begin
                o_cmd.load_char = i_in_valid;
                n_ovf           = 1'b0;
                n_has_res       = 1'b0;
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                priority if (i_stat.in_comment) begin
                    o_cmd.clr_comment = i_stat.is_nl;
                    n_state           = S_IDLE;
                end else if (i_stat.is_digit) begin
                    o_cmd.acc_digit = 1'b1;
                    n_state         = S_IDLE;
                end else if (i_stat.is_tilde) begin
                    o_cmd.set_comment = 1'b1;
                    n_state           = S_IDLE;
                end else if (i_stat.is_dollar) begin
                    o_cmd.clear_all = 1'b1;
                    n_has_res       = 1'b1;
                    n_code          = ST_END;
                    n_state         = S_FIN;
                end else begin
                    if (i_stat.pending) begin
                        if (i_stat.full) begin
                            o_cmd.drop_num = 1'b1;
                            n_ovf          = 1'b1;
                        end else begin
                            o_cmd.push = 1'b1;
                        end
                    end
                    n_state = S_OPER;
                end
            end
            S_OPER: begin
                priority if (i_stat.is_op) begin
                    if (i_stat.lt2) begin
                        n_has_res = 1'b1;
                        n_code    = ST_UNDERFLOW;
                        n_state   = S_FIN;
                    end else begin
                        o_cmd.rd_top = 1'b1;
                        n_state      = S_RD1;
                    end
                end else if (i_stat.is_print) begin
                    if (i_stat.empty) begin
                        n_has_res = 1'b1;
                        n_code    = ST_UNDERFLOW;
                        n_state   = S_FIN;
                    end else begin
                        o_cmd.rd_top = 1'b1;
                        n_state      = S_PRNT;
                    end
                end else begin
                    n_state = S_FIN;
                end
            end
            S_RD1: begin
                o_cmd.load_b    = 1'b1;
                o_cmd.rd_second = 1'b1;
                n_state         = S_RD2;
            end
            S_RD2: begin
                o_cmd.load_a = 1'b1;
                n_state      = S_EXEC;
            end
            S_EXEC: begin
                priority if (i_stat.is_div && i_stat.b_zero) begin
                    n_has_res = 1'b1;
                    n_code    = ST_DIVZERO;
                    n_state   = S_FIN;
                end else if (i_stat.is_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIVW;
                end else begin
                    o_cmd.ld_alu = 1'b1;
                    n_state      = S_WB;
                end
            end
            S_DIVW: begin
                if (i_stat.div_done) begin
                    o_cmd.ld_div = 1'b1;
                    n_state      = S_WB;
                end
            end
            S_WB: begin
                o_cmd.wr_res = 1'b1;
                n_state      = S_FIN;
            end
            S_PRNT: begin
                o_cmd.load_val = 1'b1;
                o_cmd.pop      = 1'b1;
                n_has_res      = 1'b1;
                n_code         = ST_PRINTED;
                n_state        = S_FIN;
            end
            S_FIN: begin
                // overflow of the pushed number goes first, then the operator's own item
                priority if (r_ovf) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit        = 1'b1;
                        o_cmd.emit_status = ST_OVERFLOW;
                        o_cmd.emit_last   = ~r_has_res;
                        n_ovf             = 1'b0;
                        if (!r_has_res) begin
                            n_state = S_IDLE;
                        end
                    end
                end else if (r_has_res) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit        = 1'b1;
                        o_cmd.emit_status = r_code;
                        o_cmd.emit_last   = 1'b1;
                        n_has_res         = 1'b0;
                        n_state           = S_IDLE;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ovf     <= 1'b0;
            r_has_res <= 1'b0;
            r_code    <= ST_PRINTED;
        end else begin
            r_state   <= n_state;
            r_ovf     <= n_ovf;
            r_has_res <= n_has_res;
            r_code    <= n_code;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

/* rtl/core/rpn_stack_calculator.sv */
// Top level of the RPN stack calculator: controller plus datapath.
//
// Input channel (i_in_valid / o_in_ready, i_char_in) takes one program character per item.
// Output channel (o_out_valid / i_out_ready) gives o_value, o_status and o_last; a character
// yields zero, one or two result items, o_last marking the final one.
// One character is worked on at a time; '/' and '%' run through the shift-subtract
// divider. A number dropped on a full stack gives an overflow item. Stack reads go one
// at a time through the single read port of the operand stack RAM, so a binary operator
// fetches its top operand first and then the second one.
// A result sits in a one-deep output register; the next character is taken while it waits.
// If the receiver stalls, the block holds at the point where it must emit a further item.
// Reset (synchronous, active low) empties the stack, clears the number being built and any
// comment, and drops an undelivered result. The stack RAM itself is not cleared.
// Overflow, underflow and divide by zero leave the stack unchanged.
module rpn_stack_calculator
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_char_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_value,
    output logic [2:0]         o_status,
    output logic               o_last
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    rpn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    rpn_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_char_in   (i_char_in),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_value     (o_value),
        .o_status    (o_status),
        .o_last      (o_last)
    );

endmodule

/* rtl/core/rpn_checker.sv */
// Port-level checks of the RPN stack calculator, bound to the top level.
module rpn_checker
    import rpn_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [31:0] o_value,
    input logic [2:0]         o_status,
    input logic               o_last
);

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_PRINTED) || (o_status == ST_UNDERFLOW)
                     || (o_status == ST_OVERFLOW) || (o_status == ST_DIVZERO)
                     || (o_status == ST_END))
        else $error("status code out of range");

    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_PRINTED)) |-> (o_value == 32'sd0))
        else $error("non-print item carries a value");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while an item is in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid && $stable(o_value)
                                        && $stable(o_status) && $stable(o_last))
        else $error("stalled result changed");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("block not idle after reset");

endmodule

bind rpn_stack_calculator rpn_checker u_rpn_checker (.*);

/* dv/tb.sv */
// Self-checking testbench for the RPN stack calculator: directed table, random programs.
`timescale 1ns / 100ps

module tb
    import rpn_pkg::*;
();

    localparam int STK_DEPTH = 16;
    localparam int N_RANDOM  = 1400;
    localparam int CYC_LIMIT = 1000000;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  status;
        logic        last;
    } t_calc_result;

    typedef struct packed {
        logic [7:0]  ch;
        logic        typed;
        logic [2:0]  status;
        logic [31:0] value;
    } t_stim_row;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PATTERN} t_rx_mode;

    localparam int NDIR = 27;
    localparam t_stim_row DIR_TAB [NDIR] = '{
        '{CH_PRINT,  1'b1, ST_UNDERFLOW, 32'd0},
        '{CH_DIV,    1'b1, ST_UNDERFLOW, 32'd0},
        '{"4",       1'b0, ST_PRINTED,   32'd0},
        '{"2",       1'b0, ST_PRINTED,   32'd0},
        '{CH_TILDE,  1'b0, ST_PRINTED,   32'd0},
        '{"9",       1'b0, ST_PRINTED,   32'd0},
        '{CH_NL,     1'b0, ST_PRINTED,   32'd0},
        '{"7",       1'b0, ST_PRINTED,   32'd0},
        '{CH_SPACE,  1'b0, ST_PRINTED,   32'd0},
        '{"0",       1'b0, ST_PRINTED,   32'd0},
        '{8'h00,     1'b0, ST_PRINTED,   32'd0},
        '{CH_DIV,    1'b1, ST_DIVZERO,   32'd0},
        '{CH_MOD,    1'b1, ST_DIVZERO,   32'd0},
        '{CH_PRINT,  1'b1, ST_PRINTED,   32'd0},
        '{CH_PRINT,  1'b1, ST_PRINTED,   32'd427},
        '{"3",       1'b0, ST_PRINTED,   32'd0},
        '{CH_SPACE,  1'b0, ST_PRINTED,   32'd0},
        '{"5",       1'b0, ST_PRINTED,   32'd0},
        '{CH_SUB,    1'b0, ST_PRINTED,   32'd0},
        '{"7",       1'b0, ST_PRINTED,   32'd0},
        '{CH_MUL,    1'b0, ST_PRINTED,   32'd0},
        '{"6",       1'b0, ST_PRINTED,   32'd0},
        '{CH_ADD,    1'b0, ST_PRINTED,   32'd0},
        '{CH_PRINT,  1'b1, ST_PRINTED,   32'hFFFF_FFF8},
        '{"8",       1'b0, ST_PRINTED,   32'd0},
        '{CH_DOLLAR, 1'b1, ST_END,       32'd0},
        '{8'hFF,     1'b0, ST_PRINTED,   32'd0}
    };

    localparam logic [7:0] OP_CHARS [6] = '{CH_ADD, CH_SUB, CH_MUL, CH_DIV, CH_MOD, CH_PRINT};

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [7:0]         i_char_in;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [31:0] o_value;
    logic [2:0]         o_status;
    logic               o_last;

    // hand-typed expectation travelling with the current item
    logic               row_typed;
    logic [2:0]         row_status;
    logic [31:0]        row_value;

    // calculator state as predicted
    logic [31:0]        calc_stack [STK_DEPTH];
    int                 calc_depth;
    logic [31:0]        calc_acc;
    logic               calc_digits;
    logic               calc_comment;

    t_calc_result       step_out [$];
    t_calc_result       exp_q [$];
    t_calc_result       want;
    logic [7:0]         prog_q [$];
    int                 n_fail = 0;
    int                 cyc_cnt = 0;
    int                 burst_left;
    t_rx_mode           rx_mode = RX_OPEN;
    int                 mode_left = 0;
    logic [7:0]         rx_pat = 8'b1011_0010;

    rpn_stack_calculator #(.STACK_DEPTH(STK_DEPTH)) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_char_in  (i_char_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_value    (o_value),
        .o_status   (o_status),
        .o_last     (o_last)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic void add_result(logic [31:0] v, logic [2:0] st);
        t_calc_result r;
        r.value  = v;
        r.status = st;
        r.last   = 1'b0;
        step_out.push_back(r);
    endfunction

    task automatic step_calc(input logic [7:0] ch);
        logic [31:0] a, b, r;
        longint      sa, sb, q;
        step_out.delete();
        if (calc_comment) begin
            if (ch == CH_NL) calc_comment = 1'b0;
        end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
            calc_acc    = calc_acc * 32'd10 + {24'd0, ch - CH_ZERO};
            calc_digits = 1'b1;
        end else if (ch == CH_TILDE) begin
            calc_comment = 1'b1;
        end else if (ch == CH_DOLLAR) begin
            calc_depth  = 0;
            calc_acc    = '0;
            calc_digits = 1'b0;
            add_result('0, ST_END);
        end else begin
            if (calc_digits) begin
                if (calc_depth >= STK_DEPTH) begin
                    add_result('0, ST_OVERFLOW);
                end else begin
                    calc_stack[calc_depth] = calc_acc;
                    calc_depth++;
                end
                calc_acc    = '0;
                calc_digits = 1'b0;
            end
            if (ch == CH_ADD || ch == CH_SUB || ch == CH_MUL || ch == CH_DIV || ch == CH_MOD) begin
                if (calc_depth < 2) begin
                    add_result('0, ST_UNDERFLOW);
                end else begin
                    a  = calc_stack[calc_depth-2];
                    b  = calc_stack[calc_depth-1];
                    sa = $signed(a);
                    sb = $signed(b);
                    if ((ch == CH_DIV || ch == CH_MOD) && b == '0) begin
                        add_result('0, ST_DIVZERO);
                    end else begin
                        case (ch)
                            CH_ADD: r = a + b;
                            CH_SUB: r = a - b;
                            CH_MUL: r = a * b;
                            CH_DIV: begin
                                q = sa / sb;
                                r = q[31:0];
                            end
                            default: begin
                                q = sa % sb;
                                r = q[31:0];
                            end
                        endcase
                        calc_depth--;
                        calc_stack[calc_depth-1] = r;
                    end
                end
            end else if (ch == CH_PRINT) begin
                if (calc_depth == 0) begin
                    add_result('0, ST_UNDERFLOW);
                end else begin
                    calc_depth--;
                    add_result(calc_stack[calc_depth], ST_PRINTED);
                end
            end
        end
    endtask

    // input monitor: predict at acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            calc_depth   = 0;
            calc_acc     = '0;
            calc_digits  = 1'b0;
            calc_comment = 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            step_calc(i_char_in);
            if (row_typed) begin
                exp_q.push_back(t_calc_result'{row_value, row_status, 1'b1});
            end else begin
                foreach (step_out[k])
                    exp_q.push_back(t_calc_result'{step_out[k].value, step_out[k].status,
                                                   k == step_out.size() - 1});
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (exp_q.size() == 0) begin
                $error("unexpected item: value %0d status %0d last %0d",
                       o_value, o_status, o_last);
                n_fail++;
            end else begin
                want = exp_q.pop_front();
                if (o_value !== want.value) begin
                    $error("value: expected %0d, got %0d", $signed(want.value), o_value);
                    n_fail++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    n_fail++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_last);
                    n_fail++;
                end
            end
        end
    end

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            rx_mode   <= t_rx_mode'($urandom_range(0, 3));
            mode_left <= $urandom_range(50, 400);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (rx_mode)
            RX_OPEN:   i_out_ready <= 1'b1;
            RX_COIN:   i_out_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: i_out_ready <= ($urandom_range(0, 7) == 0);
            default: begin
                i_out_ready <= rx_pat[0];
                rx_pat      <= {rx_pat[0], rx_pat[7:1]};
            end
        endcase
    end

    always @(posedge i_clk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt == CYC_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_char(input logic [7:0] ch, input logic typed, input logic [2:0] st,
                             input logic [31:0] val);
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
        i_in_valid <= 1'b1;
        i_char_in  <= ch;
        row_typed  <= typed;
        row_status <= st;
        row_value  <= val;
        do @(posedge i_clk); while (!o_in_ready);
        burst_left--;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (exp_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == CH_NL) b = 8'h0B;
        return b;
    endfunction

    function automatic logic [63:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 64'd0;
            1:       return 64'd1;
            2:       return 64'd2147483648;
            3:       return 64'd4294967295;
            4:       return {$urandom, $urandom};
            5:       return {32'd0, $urandom};
            default: return 64'($urandom_range(0, 999));
        endcase
    endfunction

    // decimal digits of v, now and then split by a comment
    task automatic add_number(input logic [63:0] v);
        logic [7:0]  digs [$];
        logic [63:0] d;
        int          split;
        do begin
            d = v % 64'd10;
            digs.push_front(CH_ZERO + d[7:0]);
            v = v / 64'd10;
        end while (v != 0);
        split = ($urandom_range(0, 9) == 0) ? $urandom_range(0, digs.size() - 1) : -1;
        foreach (digs[k]) begin
            if (k == split) begin
                prog_q.push_back(CH_TILDE);
                repeat ($urandom_range(0, 5)) prog_q.push_back(noise_byte());
                prog_q.push_back(CH_NL);
            end
            prog_q.push_back(digs[k]);
        end
    endtask

    task automatic build_program();
        int pick, gd, cnt;
        gd = 0;
        while (prog_q.size() < N_RANDOM) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                add_number(pick_value());
                gd++;
                case ($urandom_range(0, 5))
                    0, 1, 2: prog_q.push_back(CH_SPACE);
                    3:       prog_q.push_back(CH_NL);
                    4:       prog_q.push_back(8'($urandom_range(0, 255)));
                    default: ;
                endcase
            end else if (pick < 74) begin
                if (gd >= 2 || $urandom_range(0, 3) == 0)
                    prog_q.push_back(OP_CHARS[$urandom_range(0, 5)]);
                else
                    prog_q.push_back(CH_PRINT);
                if (gd > 0) gd--;
            end else if (pick < 78) begin
                cnt = $urandom_range(12, 19);
                repeat (cnt) begin
                    add_number(pick_value());
                    prog_q.push_back(CH_SPACE);
                end
                gd = (gd + cnt > STK_DEPTH) ? STK_DEPTH : gd + cnt;
            end else if (pick < 84) begin
                prog_q.push_back(CH_TILDE);
                repeat ($urandom_range(0, 6)) prog_q.push_back(noise_byte());
                prog_q.push_back(CH_NL);
            end else if (pick < 86) begin
                prog_q.push_back(CH_DOLLAR);
                gd = 0;
            end else if (pick < 89) begin
                // most negative value over minus one
                add_number(64'd2147483648);
                prog_q.push_back(CH_SPACE);
                add_number(64'd4294967295);
                prog_q.push_back($urandom_range(0, 1) ? CH_DIV : CH_MOD);
                prog_q.push_back(CH_PRINT);
            end else begin
                prog_q.push_back(8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        burst_left = 0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_char_in  <= '0;
        row_typed  <= 1'b0;
        row_status <= ST_PRINTED;
        row_value  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIR_TAB[k])
            send_char(DIR_TAB[k].ch, DIR_TAB[k].typed, DIR_TAB[k].status, DIR_TAB[k].value);
        wait_drained();

        build_program();
        foreach (prog_q[k]) begin
            if ($urandom_range(0, 299) == 0) wait_drained();
            send_char(prog_q[k], 1'b0, ST_PRINTED, '0);
        end
        wait_drained();
        repeat (64) @(posedge i_clk);

        if (n_fail == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
